// ===== rtl/bcg_pkg.sv =====
// bcg_pkg: field widths, outcome and kind codes, and the control/status
// structs shared by the buffer cache cells and the top level
// depends on nothing
`timescale 1ns / 1ps

package bcg_pkg;

    localparam int DEV_W = 8;
    localparam int BLK_W = 32;
    localparam int OUT_W = 3;
    localparam int IDX_W = 4;

    localparam logic KIND_GET     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [OUT_W-1:0] OUT_HIT      = 3'd0;
    localparam logic [OUT_W-1:0] OUT_MISS     = 3'd1;
    localparam logic [OUT_W-1:0] OUT_BUSY     = 3'd2;
    localparam logic [OUT_W-1:0] OUT_NOFREE   = 3'd3;
    localparam logic [OUT_W-1:0] OUT_RELEASED = 3'd4;
    localparam logic [OUT_W-1:0] OUT_REL_ERR  = 3'd5;

    typedef struct packed {
        logic write_tag;
        logic set_lock;
        logic clr_lock;
    } t_tag_ctl;

    typedef struct packed {
        logic match;
        logic locked;
    } t_tag_sts;

    typedef struct packed {
        logic drop;
        logic append;
    } t_list_ctl;

endpackage

// ===== rtl/bcg_if.sv =====
// bcg_req_if and bcg_rsp_if: valid/ready channels for requests and results
// depends on bcg_pkg
`timescale 1ns / 1ps

interface bcg_req_if;
    import bcg_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] blkno;

    modport source (output valid, kind, device, blkno, input ready);
    modport sink (input valid, kind, device, blkno, output ready);
endinterface

interface bcg_rsp_if;
    import bcg_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] outcome;
    logic [IDX_W-1:0] buffer_index;

    modport source (output valid, outcome, buffer_index, input ready);
    modport sink (input valid, outcome, buffer_index, output ready);
endinterface

// ===== rtl/bcg_tag_cell.sv =====
// bcg_tag_cell: one buffer's tag, valid bit and lock bit with its tag compare
// depends on bcg_pkg
`timescale 1ns / 1ps

module bcg_tag_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_capture,
    input  logic [bcg_pkg::DEV_W-1:0]  i_cmp_device,
    input  logic [bcg_pkg::BLK_W-1:0]  i_cmp_block,
    input  logic [bcg_pkg::DEV_W-1:0]  i_wr_device,
    input  logic [bcg_pkg::BLK_W-1:0]  i_wr_block,
    input  bcg_pkg::t_tag_ctl          i_ctl,
    output bcg_pkg::t_tag_sts          o_sts
);
    import bcg_pkg::*;

    logic             r_valid;
    logic             r_locked;
    logic             r_match;
    logic [DEV_W-1:0] r_device;
    logic [BLK_W-1:0] r_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_locked <= 1'b0;
            r_match  <= 1'b0;
        end else begin
            if (i_capture) begin
                r_match <= r_valid && (r_device == i_cmp_device) && (r_block == i_cmp_block);
            end
            if (i_ctl.write_tag) begin
                r_valid <= 1'b1;
            end
            if (i_ctl.set_lock) begin
                r_locked <= 1'b1;
            end else if (i_ctl.clr_lock) begin
                r_locked <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write_tag) begin
            r_device <= i_wr_device;
            r_block  <= i_wr_block;
        end
    end

    assign o_sts.match  = r_match;
    assign o_sts.locked = r_locked;

endmodule

// ===== rtl/bcg_list_cell.sv =====
// bcg_list_cell: one position of the free list; closes gaps by taking its
// right neighbor's entry and appends where the occupied run ends
// depends on bcg_pkg
`timescale 1ns / 1ps

module bcg_list_cell #(
    parameter int IW    = 4,
    parameter int INDEX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcg_pkg::t_list_ctl i_ctl,
    input  logic [IW-1:0]      i_key,
    input  logic [IW-1:0]      i_next_entry,
    input  logic               i_next_occ,
    input  logic               i_prev_occ,
    input  logic               i_shift_in,
    output logic [IW-1:0]      o_entry,
    output logic               o_occ,
    output logic               o_shift
);
    import bcg_pkg::*;

    logic [IW-1:0] r_entry;
    logic          r_occ;

    // shift from here on once the dropped entry has been passed
    assign o_shift = i_shift_in || (r_occ && (r_entry == i_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= IW'(INDEX);
            r_occ   <= 1'b1;
        end else if (i_ctl.drop && o_shift) begin
            r_entry <= i_next_entry;
            r_occ   <= i_next_occ;
        end else if (i_ctl.append && !r_occ && i_prev_occ) begin
            r_entry <= i_key;
            r_occ   <= 1'b1;
        end
    end

    assign o_entry = r_entry;
    assign o_occ   = r_occ;

endmodule

// ===== rtl/buffer_cache_getblk_lru.sv =====
// buffer_cache_getblk_lru: buffer cache lookup with a least-recently-released
// free list; top level with control, result register and assertions
// depends on bcg_pkg, bcg_if, bcg_tag_cell, bcg_list_cell
//
// usage
//   i_req carries a request: kind (get or release), device, blkno.
//   o_rsp returns one result per request: outcome and buffer_index.
//   a request is handled in order: the accept edge registers the tag
//   compare in each tag cell, then the edge on which the result register
//   is free updates locks, tags and the free-list cell chain, loads the
//   result register and raises o_rsp.valid. i_req.ready is high again once
//   that update is done, so no new request enters while one is in progress.
//   if the receiver stalls with a result still held, the block accepts one
//   more request and holds its update until the result register is taken.
//   reset clears all valid and lock bits, empties the result register and
//   loads the free list with buffers 0 to BUFFERS-1 in order.
`timescale 1ns / 1ps

module buffer_cache_getblk_lru #(
    parameter int BUFFERS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcg_req_if.sink    i_req,
    bcg_rsp_if.source  o_rsp
);
    import bcg_pkg::*;

    localparam int IW = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic             r_state;
    logic             r_kind;
    logic [DEV_W-1:0] r_device;
    logic [BLK_W-1:0] r_block;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_outcome;
    logic [IDX_W-1:0] r_index;

    logic             n_state;
    logic [OUT_W-1:0] n_outcome;
    logic [IDX_W-1:0] n_index;

    t_tag_sts         w_sts [BUFFERS];
    t_tag_ctl         w_tag_ctl [BUFFERS];
    logic [IW-1:0]    w_entry [BUFFERS];
    logic [BUFFERS-1:0] w_occ;
    logic [BUFFERS-1:0] w_shift;
    logic [BUFFERS-1:0] w_match_vec;
    logic [BUFFERS-1:0] w_locked_vec;
    t_list_ctl        w_list_ctl;

    logic             w_accept;
    logic             w_go;
    logic             w_hit;
    logic             w_hit_locked;
    logic [IW-1:0]    w_hit_idx;
    logic [IW-1:0]    w_head;
    logic [IW-1:0]    w_key;
    logic             w_do_hit;
    logic             w_do_miss;
    logic             w_do_rel;
    logic [IW+3:0]    w_idx_wide;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_go        = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        w_hit_idx    = '0;
        w_hit        = 1'b0;
        w_hit_locked = 1'b0;
        for (int i = 0; i < BUFFERS; i++) begin
            w_match_vec[i]  = w_sts[i].match;
            w_locked_vec[i] = w_sts[i].locked;
            if (w_sts[i].match) begin
                w_hit_idx    = w_hit_idx | IW'(i);
                w_hit        = 1'b1;
                w_hit_locked = w_hit_locked | w_sts[i].locked;
            end
        end
    end

    assign w_head = w_entry[0];

    always_comb begin
        w_do_hit  = 1'b0;
        w_do_miss = 1'b0;
        w_do_rel  = 1'b0;
        n_outcome = OUT_REL_ERR;
        w_key     = w_hit_idx;
        unique case (r_kind)
            KIND_GET: begin
                if (w_hit && w_hit_locked) begin
                    n_outcome = OUT_BUSY;
                end else if (w_hit) begin
                    n_outcome = OUT_HIT;
                    w_do_hit  = 1'b1;
                end else if (w_occ[0]) begin
                    n_outcome = OUT_MISS;
                    w_do_miss = 1'b1;
                    w_key     = w_head;
                end else begin
                    n_outcome = OUT_NOFREE;
                end
            end
            KIND_RELEASE: begin
                if (w_hit && w_hit_locked && !w_occ[BUFFERS-1]) begin
                    n_outcome = OUT_RELEASED;
                    w_do_rel  = 1'b1;
                end else begin
                    n_outcome = OUT_REL_ERR;
                end
            end
            default: n_outcome = OUT_REL_ERR;
        endcase
        w_idx_wide = {4'b0000, w_key};
        if (n_outcome == OUT_NOFREE || n_outcome == OUT_REL_ERR) begin
            n_index = '0;
        end else begin
            n_index = w_idx_wide[IDX_W-1:0];
        end
    end

    assign w_list_ctl.drop   = w_go && (w_do_hit || w_do_miss);
    assign w_list_ctl.append = w_go && w_do_rel;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_req.kind;
            r_device <= i_req.device;
            r_block  <= i_req.blkno;
        end
        if (w_go) begin
            r_outcome <= n_outcome;
            r_index   <= n_index;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.outcome      = r_outcome;
    assign o_rsp.buffer_index = r_index;

    for (genvar k = 0; k < BUFFERS; k++) begin : g_cell
        localparam logic [IW-1:0] KIDX = IW'(k);

        assign w_tag_ctl[k].write_tag = w_go && w_do_miss && (w_head == KIDX);
        assign w_tag_ctl[k].set_lock  = w_go && ((w_do_hit && w_sts[k].match) ||
                                                 (w_do_miss && (w_head == KIDX)));
        assign w_tag_ctl[k].clr_lock  = w_go && w_do_rel && w_sts[k].match;

        bcg_tag_cell u_tag (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_capture    (w_accept),
            .i_cmp_device (i_req.device),
            .i_cmp_block  (i_req.blkno),
            .i_wr_device  (r_device),
            .i_wr_block   (r_block),
            .i_ctl        (w_tag_ctl[k]),
            .o_sts        (w_sts[k])
        );

        logic [IW-1:0] w_next_entry;
        logic          w_next_occ;
        logic          w_prev_occ;
        logic          w_shift_in;

        if (k == BUFFERS - 1) begin : g_last
            assign w_next_entry = '0;
            assign w_next_occ   = 1'b0;
        end else begin : g_mid
            assign w_next_entry = w_entry[k+1];
            assign w_next_occ   = w_occ[k+1];
        end
        if (k == 0) begin : g_first
            assign w_prev_occ = 1'b1;
            assign w_shift_in = 1'b0;
        end else begin : g_rest
            assign w_prev_occ = w_occ[k-1];
            assign w_shift_in = w_shift[k-1];
        end

        bcg_list_cell #(
            .IW    (IW),
            .INDEX (k)
        ) u_list (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_list_ctl),
            .i_key        (w_key),
            .i_next_entry (w_next_entry),
            .i_next_occ   (w_next_occ),
            .i_prev_occ   (w_prev_occ),
            .i_shift_in   (w_shift_in),
            .o_entry      (w_entry[k]),
            .o_occ        (w_occ[k]),
            .o_shift      (w_shift[k])
        );
    end

    // every buffer is either locked or on the free list
    a_lock_plus_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_locked_vec) + $countones(w_occ)) == BUFFERS)
        else $error("locked and free buffers do not add up to the pool");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_match_vec) <= 1)
        else $error("more than one tag matches");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready && r_state == S_EXEC) |=> $stable(r_outcome))
        else $error("result changed while stalled");

endmodule
